// ----- sv/lfo_pkg.sv -----
package lfo_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int COS_TABLE_BITS = 10;

    localparam int CMD_W       = 3;
    localparam int TIME_W      = 32;
    localparam int RATE_W      = 24;
    localparam int OFFSET_W    = 16;
    localparam int DUTY_W      = 16;
    localparam int LEVEL_W     = 17;
    localparam int TICK_W      = 24;
    localparam int PROD_W      = TIME_W + RATE_W;
    localparam int PH_W        = FRAC_BITS;
    localparam int LVL_CALC_W  = (FRAC_BITS + 2 > LEVEL_W) ? FRAC_BITS + 2 : LEVEL_W;
    localparam int DUTY_CMP_W  = (PH_W > DUTY_W) ? PH_W : DUTY_W;
    localparam int IDX_W       = COS_TABLE_BITS + 1;
    localparam int COS_ENTRIES = (1 << COS_TABLE_BITS) + 1;
    localparam int POS_RSH     = (FRAC_BITS >= COS_TABLE_BITS + 2) ?
                                 FRAC_BITS - COS_TABLE_BITS - 2 : 0;
    localparam int POS_LSH     = (FRAC_BITS >= COS_TABLE_BITS + 2) ?
                                 0 : COS_TABLE_BITS + 2 - FRAC_BITS;

    localparam logic [63:0] PI_Q30   = 64'd3373259426;
    localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
    localparam logic [63:0] ONE_FX64 = 64'd1 << FRAC_BITS;
    localparam logic [63:0] TICK_MAX = 64'hFF_FFFF;

    localparam logic [PH_W-1:0]       HALF_PH  = PH_W'(1) << (FRAC_BITS - 1);
    localparam logic [LVL_CALC_W-1:0] ONE_LV   = LVL_CALC_W'(1) << FRAC_BITS;
    localparam logic [IDX_W-1:0]      ROM_SPAN = IDX_W'(1) << COS_TABLE_BITS;

    typedef enum logic [CMD_W-1:0] {
        CMD_RAMP     = 3'd0,
        CMD_TRIANGLE = 3'd1,
        CMD_SAW      = 3'd2,
        CMD_COSINE   = 3'd3,
        CMD_PULSE    = 3'd4,
        CMD_SQUARE   = 3'd5
    } lfo_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [TIME_W-1:0]   play_time;
        logic [RATE_W-1:0]   rate;
        logic [OFFSET_W-1:0] offset;
        logic [DUTY_W-1:0]   duty;
    } lfo_sample_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [TICK_W-1:0]  tick_count;
    } lfo_wave_t;

    typedef logic [FRAC_BITS:0] cos_entry_t;
    typedef cos_entry_t cos_rom_t [COS_ENTRIES];

    // quarter-wave cosine, taylor series in q2.30, clamped and rounded half up
    function automatic cos_rom_t build_cos_rom();
        cos_rom_t           tbl;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        logic [63:0]        rnd;
        for (int k = 0; k < COS_ENTRIES; k++)
        begin
            x    = (PI_Q30 * 64'(k)) >> (COS_TABLE_BITS + 1);
            x2   = (x * x) >> 30;
            term = Q30_ONE;
            acc  = $signed(Q30_ONE);
            for (int n = 1; n <= 10; n++)
            begin
                term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
                if ((n & 1) == 1)
                    acc = acc - $signed(term);
                else
                    acc = acc + $signed(term);
            end
            if (acc < 0)
                acc = 64'sd0;
            if (acc > $signed(Q30_ONE))
                acc = $signed(Q30_ONE);
            rnd    = ($unsigned(acc) * ONE_FX64 + (Q30_ONE >> 1)) >> 30;
            tbl[k] = cos_entry_t'(rnd);
        end
        return tbl;
    endfunction

    localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

// ----- sv/lfo_waveform_generator_core.sv -----
// channel   valid          stall          payload                 direction
// sample    sample_valid   sample_stall   lfo_pkg::lfo_sample_t   in
// wave      wave_valid     wave_stall     lfo_pkg::lfo_wave_t     out
//
// four register stages: multiply, phase and rom index, rom read, level select
// one item per cycle while wave_stall is low; wave_valid rises when an item reaches the level select stage
// the rom read stage has one cosine table port, read once per item
// reset clears the stage valid bits only; no state survives between items
// a stall on wave fills bubbles first, then raises sample_stall; nothing is dropped
module lfo_waveform_generator_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  lfo_pkg::lfo_sample_t sample,
    output logic                 wave_valid,
    input  logic                 wave_stall,
    output lfo_pkg::lfo_wave_t   wave
);

    localparam int F = lfo_pkg::FRAC_BITS;
    localparam int C = lfo_pkg::COS_TABLE_BITS;

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic v4_reg, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;

    // stage 1
    logic [lfo_pkg::PROD_W-1:0]   prod_reg;
    logic [lfo_pkg::CMD_W-1:0]    cmd1_reg;
    logic [lfo_pkg::OFFSET_W-1:0] offset1_reg;
    logic [lfo_pkg::DUTY_W-1:0]   duty1_reg;

    // stage 2
    logic [lfo_pkg::PH_W-1:0]   ph_next, ph2_reg;
    logic [lfo_pkg::TICK_W-1:0] tick_next, tick2_reg;
    logic [lfo_pkg::IDX_W-1:0]  idx_next, idx2_reg;
    logic                       neg_next, neg2_reg;
    logic [lfo_pkg::CMD_W-1:0]  cmd2_reg;
    logic [lfo_pkg::DUTY_W-1:0] duty2_reg;
    logic [63:0]                tick_wide;
    logic [63:0]                pos_wide;
    logic [C-1:0]               rom_k;
    logic [1:0]                 quad;

    // stage 3
    logic [F:0]                     cos3_reg;
    logic                           neg3_reg;
    logic                           is_cos3_reg;
    logic [lfo_pkg::LVL_CALC_W-1:0] base_next, base3_reg;
    logic [lfo_pkg::TICK_W-1:0]     tick3_reg;
    logic [lfo_pkg::PH_W-1:0]       tri_d;

    // stage 4
    logic [lfo_pkg::LVL_CALC_W-1:0] level_calc;
    lfo_pkg::lfo_wave_t             wave_reg;

    assign rdy4 = !v4_reg || !wave_stall;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign sample_stall = !rdy1;
    assign wave_valid   = v4_reg;
    assign wave         = wave_reg;

    always_comb
    begin
        v1_next = rdy1 ? sample_valid : v1_reg;
        v2_next = rdy2 ? v1_reg : v2_reg;
        v3_next = rdy3 ? v2_reg : v3_reg;
        v4_next = rdy4 ? v3_reg : v4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // phase, tick saturation and cosine table index
    always_comb
    begin
        tick_wide = 64'(prod_reg) >> (2 * F);
        tick_next = (tick_wide > lfo_pkg::TICK_MAX) ? '1 : lfo_pkg::TICK_W'(tick_wide);
        ph_next   = prod_reg[2*F-1:F] + lfo_pkg::PH_W'(offset1_reg);
        pos_wide  = (64'(ph_next) >> lfo_pkg::POS_RSH) << lfo_pkg::POS_LSH;
        rom_k     = pos_wide[C-1:0];
        quad      = pos_wide[C+1:C];
        idx_next  = quad[0] ? (lfo_pkg::ROM_SPAN - lfo_pkg::IDX_W'(rom_k))
                            : lfo_pkg::IDX_W'(rom_k);
        neg_next  = quad[0] ^ quad[1];
    end

    // levels of the shapes that need no table
    always_comb
    begin
        tri_d = (ph2_reg >= lfo_pkg::HALF_PH) ? (ph2_reg - lfo_pkg::HALF_PH)
                                              : (lfo_pkg::HALF_PH - ph2_reg);
        case (cmd2_reg)
            lfo_pkg::CMD_RAMP:
                base_next = lfo_pkg::LVL_CALC_W'(ph2_reg);
            lfo_pkg::CMD_TRIANGLE:
                base_next = lfo_pkg::ONE_LV - (lfo_pkg::LVL_CALC_W'(tri_d) << 1);
            lfo_pkg::CMD_SAW:
                base_next = lfo_pkg::ONE_LV - lfo_pkg::LVL_CALC_W'(ph2_reg);
            lfo_pkg::CMD_PULSE:
                base_next = (lfo_pkg::DUTY_CMP_W'(ph2_reg) > lfo_pkg::DUTY_CMP_W'(duty2_reg))
                            ? lfo_pkg::ONE_LV : '0;
            lfo_pkg::CMD_SQUARE:
                base_next = (ph2_reg > lfo_pkg::HALF_PH) ? lfo_pkg::ONE_LV : '0;
            default:
                base_next = '0;
        endcase
    end

    always_comb
    begin
        if (!is_cos3_reg)
            level_calc = base3_reg;
        else if (neg3_reg)
            level_calc = (lfo_pkg::ONE_LV + lfo_pkg::LVL_CALC_W'(cos3_reg)) >> 1;
        else
            level_calc = (lfo_pkg::ONE_LV - lfo_pkg::LVL_CALC_W'(cos3_reg)) >> 1;
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && sample_valid)
        begin
            prod_reg    <= lfo_pkg::PROD_W'(sample.play_time) * lfo_pkg::PROD_W'(sample.rate);
            cmd1_reg    <= sample.command;
            offset1_reg <= sample.offset;
            duty1_reg   <= sample.duty;
        end
        if (rdy2 && v1_reg)
        begin
            ph2_reg   <= ph_next;
            tick2_reg <= tick_next;
            idx2_reg  <= idx_next;
            neg2_reg  <= neg_next;
            cmd2_reg  <= cmd1_reg;
            duty2_reg <= duty1_reg;
        end
        if (rdy3 && v2_reg)
        begin
            cos3_reg    <= lfo_pkg::COS_ROM[idx2_reg];
            neg3_reg    <= neg2_reg;
            is_cos3_reg <= (cmd2_reg == lfo_pkg::CMD_COSINE);
            base3_reg   <= base_next;
            tick3_reg   <= tick2_reg;
        end
        if (rdy4 && v3_reg)
        begin
            wave_reg.level      <= level_calc[lfo_pkg::LEVEL_W-1:0];
            wave_reg.tick_count <= tick3_reg;
        end
    end

    a_stage1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && rdy2 |=> v2_reg)
        else $error("stage 1 item lost on advance");

    a_stage2_moves: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && rdy3 |=> v3_reg)
        else $error("stage 2 item lost on advance");

    a_stage3_holds: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !rdy4 |=> v3_reg)
        else $error("stage 3 item dropped while blocked");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg && wave_stall))
        else $error("input stalled with a bubble in the pipeline");

endmodule
